### rtl/core/ttu_pkg.sv
// Shared types and constants for the text to unsigned parser.
`default_nettype none

package ttu_pkg;

    // Radix codes
    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_ONE   = 6'd1;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;

    // Digit code for a character that is no digit in any radix
    localparam logic [5:0] NO_DIGIT = 6'd63;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NBSP  = 8'd160;
    localparam logic [7:0] CH_FF    = 8'd255;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] LETTER_BIAS = 8'd10;

    // Classified character, as it travels from the front to the back
    typedef struct packed {
        logic       first;
        logic       blank;
        logic       minus;
        logic       plus;
        logic       zero;
        logic       x_mark;
        logic [5:0] dval;
    } t_char_info;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

### rtl/core/text_to_unsigned_parser.sv
// Streaming text to unsigned converter: one character per cycle.
// Throughput: one character per cycle; a full result register under stall
//   holds the two-entry queue, which then stalls the input.
// Path: the stopping character is written into the queue, then popped by the back end,
//   which loads the result register; a result-side stall can hold it in the queue.
// Reset: synchronous, active low; radix returns to 10, parser goes idle.
`default_nettype none

module text_to_unsigned_parser #(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [5:0]               i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [7:0]               i_ch,
    input  wire logic                     i_first,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic [OFFSET_BITS-1:0]        o_end_offset,
    output logic                          o_digits_found,
    output logic                          o_overflowed,
    output logic                          o_negative
);

    logic [5:0]          r_radix;
    ttu_pkg::t_char_info f_info;
    ttu_pkg::t_char_info q_info;
    ttu_pkg::t_q_stat    q_stat;
    logic                q_push;
    logic                q_pop;

    // Radix register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= ttu_pkg::RADIX_RESET;
        end else if (i_cfg_we) begin
            r_radix <= i_cfg_data;
        end
    end

    assign o_in_stall = q_stat.full;
    assign q_push     = i_in_valid && !q_stat.full;

    ttu_front u_front (
        .i_ch    (i_ch),
        .i_first (i_first),
        .o_info  (f_info)
    );

    ttu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (f_info),
        .i_pop   (q_pop),
        .o_data  (q_info),
        .o_stat  (q_stat)
    );

    ttu_back #(
        .VALUE_BITS  (VALUE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_radix        (r_radix),
        .i_avail        (!q_stat.empty),
        .i_info         (q_info),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_end_offset   (o_end_offset),
        .o_digits_found (o_digits_found),
        .o_overflowed   (o_overflowed),
        .o_negative     (o_negative)
    );

`ifndef ASSERT_OFF
    // Queue cannot be both full and empty
    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    // Overflow only reported with digits
    a_ovf_dig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed) |-> o_digits_found)
        else $error("overflow without digits");

    // No digits gives zero value and zero offset
    a_no_dig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_digits_found) |-> (o_value == '0 && o_end_offset == '0))
        else $error("empty parse with nonzero result");

    // Positive saturation is all ones
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflowed && !o_negative) |-> (o_value == '1))
        else $error("saturated value not all ones");
`endif

endmodule

`default_nettype wire

### rtl/core/ttu_front.sv
// Front end: classifies each incoming character.
`default_nettype none

module ttu_front (
    input  wire logic [7:0]          i_ch,
    input  wire logic                i_first,
    output ttu_pkg::t_char_info      o_info
);

    logic [5:0] dval;
    logic       blank;

    // Whitespace set
    always_comb begin
        blank = (i_ch inside {[ttu_pkg::CH_TAB:ttu_pkg::CH_CR], ttu_pkg::CH_SPACE,
                              ttu_pkg::CH_NBSP, ttu_pkg::CH_FF});
    end

    // Digit value, either letter case
    always_comb begin
        if (i_ch inside {[ttu_pkg::CH_ZERO:ttu_pkg::CH_NINE]}) begin
            dval = 6'(i_ch - ttu_pkg::CH_ZERO);
        end else if (i_ch inside {[ttu_pkg::CH_UA:ttu_pkg::CH_UZ]}) begin
            dval = 6'(i_ch - ttu_pkg::CH_UA + ttu_pkg::LETTER_BIAS);
        end else if (i_ch inside {[ttu_pkg::CH_LA:ttu_pkg::CH_LZ]}) begin
            dval = 6'(i_ch - ttu_pkg::CH_LA + ttu_pkg::LETTER_BIAS);
        end else begin
            dval = ttu_pkg::NO_DIGIT;
        end
    end

    assign o_info.first  = i_first;
    assign o_info.blank  = blank;
    assign o_info.minus  = (i_ch == ttu_pkg::CH_MINUS);
    assign o_info.plus   = (i_ch == ttu_pkg::CH_PLUS);
    assign o_info.zero   = (i_ch == ttu_pkg::CH_ZERO);
    assign o_info.x_mark = (i_ch == ttu_pkg::CH_LX) || (i_ch == ttu_pkg::CH_UX);
    assign o_info.dval   = dval;

endmodule

`default_nettype wire

### rtl/core/ttu_queue.sv
// Two-entry queue of classified characters between front and back.
`default_nettype none

module ttu_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ttu_pkg::t_char_info i_data,
    input  wire logic                i_pop,
    output ttu_pkg::t_char_info      o_data,
    output ttu_pkg::t_q_stat         o_stat
);

    ttu_pkg::t_char_info r_mem [2];
    logic                r_wr;
    logic                r_rd;
    logic [1:0]          r_count;
    logic [1:0]          n_count;

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

`default_nettype wire

### rtl/core/ttu_back.sv
// Back end: parse sequencer, digit accumulator and result register.
`default_nettype none

module ttu_back #(
    parameter int VALUE_BITS  = 32,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [5:0]               i_radix,
    input  wire logic                     i_avail,
    input  wire ttu_pkg::t_char_info      i_info,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic [OFFSET_BITS-1:0]        o_end_offset,
    output logic                          o_digits_found,
    output logic                          o_overflowed,
    output logic                          o_negative
);

    localparam int WB = VALUE_BITS + 7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_START,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase                  r_phase;
    logic [VALUE_BITS-1:0]   r_acc;
    logic [5:0]              r_base;
    logic                    r_sign;
    logic                    r_ovf;
    logic                    r_dig;
    logic [OFFSET_BITS-1:0]  r_pos;

    t_phase                  n_phase;
    logic [VALUE_BITS-1:0]   n_acc;
    logic [5:0]              n_base;
    logic                    n_sign;
    logic                    n_ovf;
    logic                    n_dig;
    logic [OFFSET_BITS-1:0]  n_pos;

    logic                    live;
    logic                    start;
    logic                    do_scan;
    logic                    do_emit;
    logic                    emit_ok;
    logic                    got;
    logic [WB-1:0]           mac;
    logic                    fits;
    logic [VALUE_BITS-1:0]   res_mag;
    logic [VALUE_BITS-1:0]   res_value;
    logic                    out_free;

    // Take an item whenever the result slot can accept one
    assign out_free = !o_out_valid || !i_out_stall;
    assign o_pop    = i_avail && out_free;

    // Per-character step
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_base  = r_base;
        n_sign  = r_sign;
        n_ovf   = r_ovf;
        n_dig   = r_dig;
        n_pos   = r_pos;
        live    = 1'b0;
        start   = 1'b0;
        do_scan = 1'b0;
        do_emit = 1'b0;
        emit_ok = 1'b0;
        mac     = '0;
        fits    = 1'b0;
        if (o_pop) begin
            // restart or advance position
            if (i_info.first) begin
                n_phase = PH_LEAD;
                n_acc   = '0;
                n_base  = i_radix;
                n_sign  = 1'b0;
                n_ovf   = 1'b0;
                n_dig   = 1'b0;
                n_pos   = '0;
                live    = 1'b1;
            end else if (r_phase != PH_IDLE && r_phase != PH_DONE) begin
                live = 1'b1;
                if (r_pos != '1) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            if (live) begin
                case (n_phase)
                    PH_LEAD: begin
                        if (i_info.blank) begin
                            n_phase = PH_LEAD;
                        end else if (i_info.minus) begin
                            n_sign  = 1'b1;
                            n_phase = PH_START;
                        end else if (i_info.plus) begin
                            n_phase = PH_START;
                        end else begin
                            start = 1'b1;
                        end
                    end
                    PH_START: start = 1'b1;
                    PH_ZERO: begin
                        if (i_info.x_mark) begin
                            n_base  = ttu_pkg::RADIX_HEX;
                            n_phase = PH_DIGITS;
                        end else begin
                            if (n_base == ttu_pkg::RADIX_AUTO) begin
                                n_base = ttu_pkg::RADIX_OCT;
                            end
                            // the leading zero counts as a digit
                            n_dig   = 1'b1;
                            do_scan = 1'b1;
                        end
                    end
                    PH_DIGITS: do_scan = 1'b1;
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            // first character after whitespace and sign
            if (start) begin
                if (n_base == ttu_pkg::RADIX_ONE || n_base > ttu_pkg::RADIX_MAX) begin
                    do_emit = 1'b1;
                end else if (n_base == ttu_pkg::RADIX_AUTO) begin
                    if (i_info.zero) begin
                        n_phase = PH_ZERO;
                    end else begin
                        n_base  = ttu_pkg::RADIX_DEC;
                        do_scan = 1'b1;
                    end
                end else if (n_base == ttu_pkg::RADIX_HEX && i_info.zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    do_scan = 1'b1;
                end
            end
            // digit accumulate with overflow hold
            if (do_scan) begin
                mac  = WB'(n_acc) * WB'(n_base) + WB'(i_info.dval);
                fits = (mac[WB-1:VALUE_BITS] == '0);
                if (i_info.dval >= n_base) begin
                    do_emit = 1'b1;
                    emit_ok = 1'b1;
                end else begin
                    n_dig   = 1'b1;
                    n_phase = PH_DIGITS;
                    if (fits) begin
                        n_acc = mac[VALUE_BITS-1:0];
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            if (do_emit) begin
                n_phase = PH_DONE;
            end
        end
    end

    // Result formatting
    always_comb begin
        got       = emit_ok && n_dig;
        res_mag   = got ? (n_ovf ? '1 : n_acc) : '0;
        res_value = n_sign ? (VALUE_BITS'(0) - res_mag) : res_mag;
    end

    // Parser state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_base      <= '0;
            r_sign      <= 1'b0;
            r_ovf       <= 1'b0;
            r_dig       <= 1'b0;
            r_pos       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_base  <= n_base;
            r_sign  <= n_sign;
            r_ovf   <= n_ovf;
            r_dig   <= n_dig;
            r_pos   <= n_pos;
            if (o_pop && do_emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
        if (o_pop && do_emit) begin
            o_value        <= res_value;
            o_end_offset   <= got ? n_pos : '0;
            o_digits_found <= got;
            o_overflowed   <= got && n_ovf;
            o_negative     <= n_sign;
        end
    end

endmodule

`default_nettype wire

### sim/text_to_unsigned_parser_tb.sv
// Self-checking testbench for the text to unsigned parser.
`timescale 1ns / 1ps

module text_to_unsigned_parser_tb;

    localparam int VALUE_BITS  = 32;
    localparam int OFFSET_BITS = 16;

    // Blank characters the parser skips ahead of the number
    localparam logic [7:0] BLANKS [8] = '{ttu_pkg::CH_TAB, 8'd10, 8'd11, 8'd12,
                                          ttu_pkg::CH_CR, ttu_pkg::CH_SPACE,
                                          ttu_pkg::CH_NBSP, ttu_pkg::CH_FF};

    typedef enum logic [2:0] {
        P_IDLE, P_LEAD, P_START, P_ZERO, P_DIGITS, P_DONE
    } t_parse_phase;

    typedef struct {
        logic [VALUE_BITS-1:0]  value;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   digits_found;
        logic                   overflowed;
        logic                   negative;
    } t_parse_result;

    // Tracks the string being parsed and holds the results it must produce
    class t_parse_scoreboard;
        logic [5:0]             radix;
        t_parse_phase           phase;
        logic [VALUE_BITS-1:0]  acc;
        logic [5:0]             base;
        bit                     sign_seen;
        bit                     ovf_seen;
        bit                     digit_seen;
        logic [OFFSET_BITS-1:0] pos;
        t_parse_result          expected_q[$];
        int                     errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            radix      = ttu_pkg::RADIX_RESET;
            phase      = P_IDLE;
            acc        = '0;
            base       = '0;
            sign_seen  = 0;
            ovf_seen   = 0;
            digit_seen = 0;
            pos        = '0;
            expected_q.delete();
        endfunction

        function void write_radix(logic [5:0] r);
            radix = r;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit is_blank(logic [7:0] c);
            return (c >= ttu_pkg::CH_TAB && c <= ttu_pkg::CH_CR) || c == ttu_pkg::CH_SPACE
                || c == ttu_pkg::CH_NBSP || c == ttu_pkg::CH_FF;
        endfunction

        function logic [5:0] digit_of(logic [7:0] c);
            logic [7:0] v;
            if (c >= ttu_pkg::CH_ZERO && c <= ttu_pkg::CH_NINE) begin
                v = c - ttu_pkg::CH_ZERO;
                return v[5:0];
            end
            if (c >= ttu_pkg::CH_UA && c <= ttu_pkg::CH_UZ) begin
                v = c - ttu_pkg::CH_UA + ttu_pkg::LETTER_BIAS;
                return v[5:0];
            end
            if (c >= ttu_pkg::CH_LA && c <= ttu_pkg::CH_LZ) begin
                v = c - ttu_pkg::CH_LA + ttu_pkg::LETTER_BIAS;
                return v[5:0];
            end
            return ttu_pkg::NO_DIGIT;
        endfunction

        // Scan ends: queue the one result of this string
        function void finish_string(bit base_ok);
            t_parse_result r;
            bit got;
            got = base_ok && digit_seen;
            r.value = got ? (ovf_seen ? '1 : acc) : '0;
            r.end_offset = got ? pos : '0;
            if (sign_seen) r.value = '0 - r.value;
            r.digits_found = got;
            r.overflowed   = got && ovf_seen;
            r.negative     = sign_seen;
            expected_q.push_back(r);
            phase = P_DONE;
        endfunction

        // Multiply-add, or mark overflow and keep the value
        function void add_digit(logic [5:0] d);
            logic [VALUE_BITS-1:0] lim;
            logic [VALUE_BITS-1:0] rem;
            lim = {VALUE_BITS{1'b1}} / base;
            rem = {VALUE_BITS{1'b1}} % base;
            digit_seen = 1;
            if (acc < lim || (acc == lim && d <= rem))
                acc = acc * base + d;
            else
                ovf_seen = 1;
        endfunction

        function void scan(logic [7:0] c);
            logic [5:0] d;
            d = digit_of(c);
            if (d >= base) begin
                finish_string(1);
            end else begin
                add_digit(d);
                phase = P_DIGITS;
            end
        endfunction

        // First character after blanks and sign
        function void start_digits(logic [7:0] c);
            if (base == ttu_pkg::RADIX_ONE || base > ttu_pkg::RADIX_MAX) begin
                finish_string(0);
            end else if (base == ttu_pkg::RADIX_AUTO) begin
                if (c != ttu_pkg::CH_ZERO) begin
                    base = ttu_pkg::RADIX_DEC;
                    scan(c);
                end else begin
                    phase = P_ZERO;
                end
            end else if (base == ttu_pkg::RADIX_HEX && c == ttu_pkg::CH_ZERO) begin
                phase = P_ZERO;
            end else begin
                scan(c);
            end
        endfunction

        // One accepted character transfer
        function void note_char(logic [7:0] c, logic f);
            if (f) begin
                phase      = P_LEAD;
                acc        = '0;
                base       = radix;
                sign_seen  = 0;
                ovf_seen   = 0;
                digit_seen = 0;
                pos        = '0;
            end else begin
                if (phase == P_IDLE || phase == P_DONE) return;
                if (pos != {OFFSET_BITS{1'b1}}) pos++;
            end
            case (phase)
                P_LEAD: begin
                    if (is_blank(c)) begin
                    end else if (c == ttu_pkg::CH_MINUS) begin
                        sign_seen = 1;
                        phase = P_START;
                    end else if (c == ttu_pkg::CH_PLUS) begin
                        phase = P_START;
                    end else begin
                        start_digits(c);
                    end
                end
                P_START: start_digits(c);
                P_ZERO: begin
                    if (c == ttu_pkg::CH_LX || c == ttu_pkg::CH_UX) begin
                        base = ttu_pkg::RADIX_HEX;
                        phase = P_DIGITS;
                    end else begin
                        if (base == ttu_pkg::RADIX_AUTO) base = ttu_pkg::RADIX_OCT;
                        add_digit('0);
                        scan(c);
                    end
                end
                P_DIGITS: scan(c);
                default: ;
            endcase
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(t_parse_result got);
            t_parse_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, value %h offset %0d", $time,
                         got.value, got.end_offset);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value mismatch: expected %h, actual %h", $time,
                         want.value, got.value);
                errors++;
            end
            if (got.end_offset !== want.end_offset) begin
                $display("%0t: end_offset mismatch: expected %0d, actual %0d", $time,
                         want.end_offset, got.end_offset);
                errors++;
            end
            if (got.digits_found !== want.digits_found) begin
                $display("%0t: digits_found mismatch: expected %b, actual %b", $time,
                         want.digits_found, got.digits_found);
                errors++;
            end
            if (got.overflowed !== want.overflowed) begin
                $display("%0t: overflowed mismatch: expected %b, actual %b", $time,
                         want.overflowed, got.overflowed);
                errors++;
            end
            if (got.negative !== want.negative) begin
                $display("%0t: negative mismatch: expected %b, actual %b", $time,
                         want.negative, got.negative);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [5:0]             i_cfg_data  = '0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_stall;
    logic [7:0]             i_ch        = '0;
    logic                   i_first     = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [VALUE_BITS-1:0]  o_value;
    logic [OFFSET_BITS-1:0] o_end_offset;
    logic                   o_digits_found;
    logic                   o_overflowed;
    logic                   o_negative;

    bit tx_calm     = 0;
    bit rx_calm     = 0;
    bit rx_hold_req = 0;

    t_parse_scoreboard sb = new();
    logic [7:0] text_buf[$];

    text_to_unsigned_parser #(
        .VALUE_BITS (VALUE_BITS),
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_ch          (i_ch),
        .i_first       (i_first),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_value       (o_value),
        .o_end_offset  (o_end_offset),
        .o_digits_found(o_digits_found),
        .o_overflowed  (o_overflowed),
        .o_negative    (o_negative)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function int gap_len(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Watch every transfer on the three ports at the clock edge
    always @(posedge i_clk) begin : watch
        t_parse_result seen;
        if (!i_rst_n) begin
            sb.clear();
        end else begin
            if (i_cfg_we) sb.write_radix(i_cfg_data);
            if (o_out_valid && !i_out_stall) begin
                seen.value        = o_value;
                seen.end_offset   = o_end_offset;
                seen.digits_found = o_digits_found;
                seen.overflowed   = o_overflowed;
                seen.negative     = o_negative;
                sb.check_result(seen);
            end
            if (i_in_valid && !o_in_stall) sb.note_char(i_ch, i_first);
        end
    end

    // Result side: random stall, calm stretches, one long hold-off on request
    initial begin : rx_side
        int n;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                rx_hold_req = 0;
            end else if (rx_calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = gap_len(0);
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    // One character transfer; valid stays high on return
    task automatic send_char(input logic [7:0] c, input logic f);
        int gap;
        gap = gap_len(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        i_first    <= f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // A whole string with its NUL
    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
        send_char(8'h00, s.len() == 0);
    endtask

    // Close any open string, let everything drain, then set the radix
    task automatic settle_and_set_radix(input logic [5:0] r);
        send_char(8'h00, 1'b0);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random strings: mostly well-formed numbers, some noise and stray bytes
    task automatic run_random(input logic [5:0] r, input int n_items);
        int sent;
        int kind;
        int gb;
        int d;
        int ndig;
        int p;
        sent = 0;
        while (sent < n_items) begin
            text_buf.delete();
            kind = $urandom_range(0, 99);
            if (kind < 80) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3))
                        text_buf.push_back(BLANKS[$urandom_range(0, 7)]);
                p = $urandom_range(0, 9);
                if (p < 2) text_buf.push_back(ttu_pkg::CH_MINUS);
                else if (p < 4) text_buf.push_back(ttu_pkg::CH_PLUS);
                gb = (r == ttu_pkg::RADIX_AUTO || r == ttu_pkg::RADIX_ONE
                      || r > ttu_pkg::RADIX_MAX) ? 10 : int'(r);
                if ((r == ttu_pkg::RADIX_AUTO || r == ttu_pkg::RADIX_HEX)
                    && $urandom_range(0, 2) == 0) begin
                    text_buf.push_back(ttu_pkg::CH_ZERO);
                    text_buf.push_back($urandom_range(0, 1) ? ttu_pkg::CH_UX : ttu_pkg::CH_LX);
                    gb = 16;
                end else if (r == ttu_pkg::RADIX_AUTO && $urandom_range(0, 3) == 0) begin
                    text_buf.push_back(ttu_pkg::CH_ZERO);
                    gb = 8;
                end
                p = $urandom_range(0, 9);
                ndig = (p < 6) ? $urandom_range(1, 6) :
                       (p < 9) ? $urandom_range(7, 12) : $urandom_range(13, 40);
                repeat (ndig) begin
                    d = ($urandom_range(0, 3) == 0) ? gb - 1 : $urandom_range(0, gb - 1);
                    if (d < 10)
                        text_buf.push_back(8'(ttu_pkg::CH_ZERO + d));
                    else
                        text_buf.push_back(8'(($urandom_range(0, 1) ? ttu_pkg::CH_UA
                                                                    : ttu_pkg::CH_LA)
                                              + d - ttu_pkg::LETTER_BIAS));
                end
                text_buf.push_back($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)));
            end else if (kind < 95) begin
                repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) text_buf.push_back(8'h00);
            end else begin
                // stray byte outside a string start; not counted
                send_char(8'($urandom_range(0, 255)), 1'b0);
            end
            foreach (text_buf[i]) send_char(text_buf[i], i == 0);
            sent += text_buf.size();
        end
    endtask

    initial begin : stimulus
        logic [5:0] r_pick;
        int         wait_cycles;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset radix: blanks, signs, overflow, no digits, ignored bytes
        send_char("7", 1'b0);
        send_line("\t -4294967295");
        send_line("4294967296");
        send_line("+12a");
        send_line("- 5");
        send_line("");
        send_char("9", 1'b0);
        send_char(ttu_pkg::CH_NBSP, 1'b1);
        send_char(ttu_pkg::CH_FF, 1'b0);
        send_char("8", 1'b0);
        send_char(8'h00, 1'b0);

        // Auto radix: hex prefix, octal, bare prefix
        settle_and_set_radix(ttu_pkg::RADIX_AUTO);
        send_line("0x1F");
        send_line("-017");
        send_line("0xg");
        send_line("0");
        send_line("0X");
        send_line("42");

        settle_and_set_radix(ttu_pkg::RADIX_HEX);
        send_line("0xABCDEF01");
        send_line("0x");
        send_line("1ffffffff");
        send_line("Ff");

        settle_and_set_radix(ttu_pkg::RADIX_MAX);
        send_line("zZz");
        settle_and_set_radix(6'd2);
        send_line("10112");

        // Invalid radix values
        settle_and_set_radix(ttu_pkg::RADIX_ONE);
        send_line(" -5");
        settle_and_set_radix(6'd37);
        send_line("+7");
        settle_and_set_radix(6'd63);
        send_line("9");

        // Random phases over several radix settings
        settle_and_set_radix(ttu_pkg::RADIX_AUTO);
        run_random(ttu_pkg::RADIX_AUTO, 150);
        settle_and_set_radix(ttu_pkg::RADIX_HEX);
        run_random(ttu_pkg::RADIX_HEX, 120);
        settle_and_set_radix(ttu_pkg::RADIX_OCT);
        run_random(ttu_pkg::RADIX_OCT, 100);
        settle_and_set_radix(6'd2);
        run_random(6'd2, 100);

        // Long receiver hold-off while the sender keeps pushing
        settle_and_set_radix(ttu_pkg::RADIX_DEC);
        rx_hold_req = 1;
        tx_calm = 1;
        run_random(ttu_pkg::RADIX_DEC, 80);
        tx_calm = 0;

        settle_and_set_radix(ttu_pkg::RADIX_MAX);
        run_random(ttu_pkg::RADIX_MAX, 100);
        r_pick = 6'($urandom_range(0, 63));
        settle_and_set_radix(r_pick);
        run_random(r_pick, 100);

        // A stretch with no idling on either side
        settle_and_set_radix(ttu_pkg::RADIX_AUTO);
        tx_calm = 1;
        rx_calm = 1;
        run_random(ttu_pkg::RADIX_AUTO, 100);
        send_char(8'h00, 1'b0);
        rx_calm = 0;
        tx_calm = 0;

        // Drain and report
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
